FILE: src/lds_pkg.sv
`timescale 1ns / 1ps

package lds_pkg;

    localparam int N_MAX_DEF = 16;
    localparam int QDEPTH    = 4;
    localparam int QAW       = $clog2(QDEPTH);

    typedef struct packed {
        logic               is_rhs;
        logic               keep;
        logic [3:0]         row;
        logic [3:0]         col;
        logic signed [31:0] value;
        logic               last;
    } t_item;

    typedef enum logic [4:0] {
        S_IDLE, S_FK, S_FPIV, S_FJ, S_FDIV, S_FI, S_FI2, S_FI3,
        S_LD, S_MUL, S_RND, S_SUB, S_DIVW,
        S_YI, S_YI2, S_YJ, S_XI, S_XI2, S_XJ, S_XD, S_EI, S_EO
    } t_state;

    typedef enum logic [1:0] {
        PH_FAC, PH_FWD, PH_BWD
    } t_phase;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sh7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sh8000_0000) begin
            return -32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

FILE: src/lds_ram.sv
`timescale 1ns / 1ps

module lds_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/lds_front.sv
`timescale 1ns / 1ps

module lds_front
    import lds_pkg::*;
#(
    parameter int N_MAX = N_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,
    input  logic        i_s_tuser,
    input  logic        i_s_tlast,
    output logic        o_q_valid,
    output t_item       o_q_item,
    input  logic        i_q_pop
);

    t_item          r_mem [QDEPTH];
    logic [QAW-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [QAW:0]   r_cnt, n_cnt;
    t_item          w_item;
    logic           w_push;

    always_comb begin
        w_item.is_rhs = i_s_tuser;
        w_item.row    = i_s_tdata[3:0];
        w_item.col    = i_s_tdata[7:4];
        w_item.value  = i_s_tdata[39:8];
        w_item.last   = i_s_tlast;
        w_item.keep   = (32'(i_s_tdata[3:0]) < N_MAX)
                        && (i_s_tuser || (32'(i_s_tdata[7:4]) < N_MAX));
    end

    assign o_s_tready = (r_cnt != (QAW+1)'(QDEPTH));
    assign w_push     = i_s_tvalid && o_s_tready;
    assign o_q_valid  = (r_cnt != '0);
    assign o_q_item   = r_mem[r_rd];

    always_comb begin
        n_wr  = w_push ? r_wr + 1'b1 : r_wr;
        n_rd  = i_q_pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + (QAW+1)'(w_push) - (QAW+1)'(i_q_pop);
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QAW+1)'(QDEPTH))
        else $error("queue count beyond depth");

endmodule

FILE: src/lds_div.sv
`timescale 1ns / 1ps

module lds_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_num,
    input  logic signed [31:0] i_den,
    output logic               o_done,
    output logic signed [31:0] o_quo,
    output logic               o_zero
);

    logic        r_busy, r_done, r_zero, r_neg;
    logic [5:0]  r_cnt;
    logic [32:0] r_rem;
    logic [47:0] r_num, r_quo;
    logic [31:0] r_den;
    logic [32:0] w_sh;
    logic        w_ge;
    logic [31:0] w_anum, w_aden;

    assign w_anum = i_num[31] ? 32'(-i_num) : 32'(i_num);
    assign w_aden = i_den[31] ? 32'(-i_den) : 32'(i_den);
    assign w_sh   = {r_rem[31:0], r_num[47]};
    assign w_ge   = (w_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= {w_anum, 16'h0};
            r_den  <= w_aden;
            r_rem  <= '0;
            r_quo  <= '0;
            r_neg  <= i_num[31] ^ i_den[31];
            r_zero <= (i_den == '0);
        end else if (r_busy) begin
            r_num <= {r_num[46:0], 1'b0};
            r_rem <= w_ge ? w_sh - {1'b0, r_den} : w_sh;
            r_quo <= {r_quo[46:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= (i_start && (i_den == '0)) || (r_busy && (r_cnt == 6'd1));
            if (i_start) begin
                r_busy <= (i_den != '0);
                r_cnt  <= 6'd48;
            end else if (r_busy) begin
                r_cnt  <= r_cnt - 6'd1;
                r_busy <= (r_cnt != 6'd1);
            end
        end
    end

    always_comb begin
        if (r_zero) begin
            o_quo = '0;
        end else if (r_neg) begin
            o_quo = (r_quo > 48'h8000_0000) ? -32'sh8000_0000 : 32'(-r_quo[31:0]);
        end else begin
            o_quo = (r_quo > 48'h7FFF_FFFF) ? 32'sh7FFF_FFFF : r_quo[31:0];
        end
    end

    assign o_done = r_done;
    assign o_zero = r_zero;

endmodule

FILE: src/lds_back.sv
`timescale 1ns / 1ps

module lds_back
    import lds_pkg::*;
#(
    parameter int N_MAX = N_MAX_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  t_item              i_q_item,
    output logic               o_q_pop,
    input  logic [4:0]         i_size,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [3:0]         o_index,
    output logic signed [31:0] o_solution,
    output logic               o_final,
    output logic               o_zero_pivot
);

    localparam int AW  = $clog2(N_MAX * N_MAX);
    localparam int SW  = $clog2(N_MAX);
    localparam int LIM = (N_MAX < 16) ? N_MAX : 16;

    t_state r_state, n_state;
    t_phase r_phase;
    logic [4:0] r_n, r_k, r_j, r_i;
    logic signed [31:0] r_piv, r_m, r_opa, r_opb, r_acc, r_q;
    logic signed [63:0] r_prod;
    logic r_err;
    logic r_ov, r_olast, r_ozp;
    logic [3:0] r_oidx;
    logic signed [31:0] r_osol;

    logic f_we;
    logic [AW-1:0] f_waddr, f_raddr;
    logic [31:0] f_wdata, f_rdata;
    logic h_we;
    logic [SW-1:0] h_waddr, h_raddr;
    logic [31:0] h_rdata;
    logic s_we;
    logic [SW-1:0] s_waddr, s_raddr;
    logic [31:0] s_wdata, s_rdata;

    logic w_div_start, w_div_done, w_div_zero;
    logic signed [31:0] w_div_num, w_div_den, w_div_quo;
    logic signed [31:0] w_sub;
    logic [4:0] w_n;
    logic w_oload;

    function automatic logic [AW-1:0] fa(input logic [4:0] r, input logic [4:0] c);
        return AW'(r) * AW'(N_MAX) + AW'(c);
    endfunction

    assign w_n = (i_size == 5'd0) ? 5'd1 : ((i_size > 5'(LIM)) ? 5'(LIM) : i_size);
    assign w_sub = sat32(64'(r_acc) - 64'(r_q));
    assign w_oload = (r_state == S_EO) && (!r_ov || i_ready);

    lds_ram #(.WIDTH(32), .DEPTH(N_MAX * N_MAX)) u_factor (
        .i_clk(i_clk), .i_we(f_we), .i_waddr(f_waddr), .i_wdata(f_wdata),
        .i_raddr(f_raddr), .o_rdata(f_rdata)
    );

    lds_ram #(.WIDTH(32), .DEPTH(N_MAX)) u_rhs (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(h_waddr), .i_wdata(i_q_item.value),
        .i_raddr(h_raddr), .o_rdata(h_rdata)
    );

    lds_ram #(.WIDTH(32), .DEPTH(N_MAX)) u_sol (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(s_raddr), .o_rdata(s_rdata)
    );

    lds_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_num(w_div_num), .i_den(w_div_den),
        .o_done(w_div_done), .o_quo(w_div_quo), .o_zero(w_div_zero)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid && i_q_item.last) n_state = S_FK;
            end
            S_FK:   n_state = (r_k + 5'd1 >= r_n) ? S_YI : S_FPIV;
            S_FPIV: n_state = S_FJ;
            S_FJ:   n_state = (r_j >= r_n) ? S_FK : S_FDIV;
            S_FDIV: n_state = S_DIVW;
            S_DIVW: begin
                if (w_div_done) begin
                    if (r_phase == PH_FAC) begin
                        n_state = S_FI;
                    end else begin
                        n_state = (r_i == 5'd0) ? S_EI : S_XI;
                    end
                end
            end
            S_FI:   n_state = (r_i >= r_n) ? S_FJ : S_FI2;
            S_FI2:  n_state = S_FI3;
            S_FI3:  n_state = S_MUL;
            S_LD:   n_state = S_MUL;
            S_MUL:  n_state = S_RND;
            S_RND:  n_state = S_SUB;
            S_SUB: begin
                case (r_phase)
                    PH_FAC:  n_state = S_FI;
                    PH_FWD:  n_state = S_YJ;
                    default: n_state = S_XJ;
                endcase
            end
            S_YI:   n_state = (r_i >= r_n) ? S_XI : S_YI2;
            S_YI2:  n_state = S_YJ;
            S_YJ:   n_state = (r_j < r_i) ? S_LD : S_YI;
            S_XI:   n_state = S_XI2;
            S_XI2:  n_state = S_XJ;
            S_XJ:   n_state = (r_j == r_i) ? S_XD : S_LD;
            S_XD:   n_state = S_DIVW;
            S_EI:   n_state = S_EO;
            S_EO: begin
                if (w_oload) n_state = (r_i == r_n - 5'd1) ? S_IDLE : S_EI;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop     = 1'b0;
        f_we        = 1'b0;
        f_waddr     = fa({1'b0, i_q_item.row}, {1'b0, i_q_item.col});
        f_wdata     = i_q_item.value;
        f_raddr     = fa(r_k, r_k);
        h_we        = 1'b0;
        h_waddr     = SW'(i_q_item.row);
        h_raddr     = SW'(r_i);
        s_we        = 1'b0;
        s_waddr     = SW'(r_i);
        s_wdata     = r_acc;
        s_raddr     = SW'(r_j);
        w_div_start = 1'b0;
        w_div_num   = r_acc;
        w_div_den   = f_rdata;
        case (r_state)
            S_IDLE: begin
                o_q_pop = i_q_valid;
                f_we    = i_q_valid && !i_q_item.is_rhs && i_q_item.keep;
                h_we    = i_q_valid && i_q_item.is_rhs && i_q_item.keep;
            end
            S_FJ:   f_raddr = fa(r_j, r_k);
            S_FDIV: begin
                w_div_start = 1'b1;
                w_div_num   = f_rdata;
                w_div_den   = r_piv;
            end
            S_DIVW: begin
                if (w_div_done && r_phase == PH_FAC) begin
                    f_we    = 1'b1;
                    f_waddr = fa(r_j, r_k);
                    f_wdata = w_div_quo;
                end else if (w_div_done) begin
                    s_we    = 1'b1;
                    s_wdata = w_div_quo;
                end
            end
            S_FI:   f_raddr = fa(r_k, r_i);
            S_FI2:  f_raddr = fa(r_j, r_i);
            S_SUB: begin
                if (r_phase == PH_FAC) begin
                    f_we    = 1'b1;
                    f_waddr = fa(r_j, r_i);
                    f_wdata = w_sub;
                end
            end
            S_YJ: begin
                f_raddr = fa(r_i, r_j);
                s_we    = (r_j >= r_i);
            end
            S_XI:   s_raddr = SW'(r_i);
            S_XJ:   f_raddr = fa(r_i, r_j);
            S_XD:   w_div_start = 1'b1;
            S_EI:   s_raddr = SW'(r_i);
            S_EO:   s_raddr = SW'(r_i);
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_FPIV: r_piv <= f_rdata;
            S_DIVW: if (w_div_done) r_m <= w_div_quo;
            S_FI2:  r_opb <= f_rdata;
            S_FI3: begin
                r_acc <= f_rdata;
                r_opa <= r_m;
            end
            S_LD: begin
                r_opa <= f_rdata;
                r_opb <= s_rdata;
            end
            S_MUL:  r_prod <= r_opa * r_opb;
            S_RND:  r_q <= sat32((r_prod + 64'sd32768) >>> 16);
            S_SUB:  r_acc <= w_sub;
            S_YI2:  r_acc <= h_rdata;
            S_XI2:  r_acc <= s_rdata;
            default: begin
            end
        endcase
        if (w_oload) begin
            r_oidx  <= r_i[3:0];
            r_osol  <= s_rdata;
            r_olast <= (r_i == r_n - 5'd1);
            r_ozp   <= r_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_FAC;
            r_n     <= 5'd1;
            r_k     <= '0;
            r_j     <= '0;
            r_i     <= '0;
            r_err   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= w_oload ? 1'b1 : (i_ready ? 1'b0 : r_ov);
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid && i_q_item.last) begin
                        r_n     <= w_n;
                        r_k     <= '0;
                        r_err   <= 1'b0;
                        r_phase <= PH_FAC;
                    end
                end
                S_FK: begin
                    r_j <= r_k + 5'd1;
                    r_i <= '0;
                end
                S_FJ:   if (r_j >= r_n) r_k <= r_k + 5'd1;
                S_DIVW: begin
                    if (w_div_done) begin
                        r_err <= r_err | w_div_zero;
                        if (r_phase == PH_FAC) begin
                            r_i <= r_k + 5'd1;
                        end else if (r_i != 5'd0) begin
                            r_i <= r_i - 5'd1;
                        end
                    end
                end
                S_FI:   if (r_i >= r_n) r_j <= r_j + 5'd1;
                S_SUB: begin
                    case (r_phase)
                        PH_FAC:  r_i <= r_i + 5'd1;
                        PH_FWD:  r_j <= r_j + 5'd1;
                        default: r_j <= r_j - 5'd1;
                    endcase
                end
                S_YI: begin
                    r_phase <= PH_FWD;
                    r_j     <= '0;
                    if (r_i >= r_n) r_i <= r_n - 5'd1;
                end
                S_YJ:   if (r_j >= r_i) r_i <= r_i + 5'd1;
                S_XI: begin
                    r_phase <= PH_BWD;
                    r_j     <= r_n - 5'd1;
                end
                S_EO: begin
                    if (w_oload && r_i != r_n - 5'd1) r_i <= r_i + 5'd1;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_valid      = r_ov;
    assign o_index      = r_oidx;
    assign o_solution   = r_osol;
    assign o_final      = r_olast;
    assign o_zero_pivot = r_ozp;

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIVW))
        else $error("divider finished outside its wait state");

    a_emit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EO) |-> (r_i < r_n))
        else $error("emit index past system size");

    a_sub_after_rnd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUB) |-> ($past(r_state) == S_RND))
        else $error("subtract step without rounded product");

endmodule

FILE: src/lu_decomposition_solver_unit.sv
`timescale 1ns / 1ps
// channel   | dir | handshake               | payload
// s (load)  | in  | i_s_tvalid / o_s_tready | tdata row,col,value; tuser kind; tlast last
// m (x)     | out | o_m_tvalid / i_m_tready | tdata index,solution; tuser zero_pivot; tlast
// cfg       | in  | i_cfg_we                | i_cfg_wdata size_used
// loads are taken into a four-entry queue one per cycle while it has room;
// the solver drains it; the run time of a solve of n unknowns is set by the
// one shared multiplier and the 48-step serial divider
// no load is taken from the queue until the last result sits in the output register
// reset (synchronous, active low) empties the queue, sets size_used to 16
// the result register accepts a new entry while its previous one is taken

module lu_decomposition_solver_unit
    import lds_pkg::*;
#(
    parameter int N_MAX = N_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // row[3:0], col[7:4], value[39:8]
    input  logic        i_s_tuser,   // kind
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // index[3:0], solution[35:4], zero fill
    output logic        o_m_tuser,   // zero_pivot
    output logic        o_m_tlast,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata
);

    logic [4:0] r_size;
    logic       w_q_valid, w_q_pop;
    t_item      w_q_item;
    logic [3:0] w_index;
    logic signed [31:0] w_solution;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= 5'd16;
        end else if (i_cfg_we) begin
            r_size <= i_cfg_wdata;
        end
    end

    lds_front #(.N_MAX(N_MAX)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser), .i_s_tlast(i_s_tlast),
        .o_q_valid(w_q_valid), .o_q_item(w_q_item), .i_q_pop(w_q_pop)
    );

    lds_back #(.N_MAX(N_MAX)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(w_q_valid), .i_q_item(w_q_item), .o_q_pop(w_q_pop),
        .i_size(r_size),
        .o_valid(o_m_tvalid), .i_ready(i_m_tready),
        .o_index(w_index), .o_solution(w_solution),
        .o_final(o_m_tlast), .o_zero_pivot(o_m_tuser)
    );

    assign o_m_tdata = {4'h0, w_solution, w_index};

endmodule
